[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[src/sps_pkg.sv]
`timescale 1ns / 1ps

package sps_pkg;

  localparam int SMALL_SIDE  = 5;
  localparam int MIDDLE_SIDE = 4;
  localparam int LARGE_SIDE  = 3;

  localparam int SMALL_BASE  = 0;
  localparam int MIDDLE_BASE = SMALL_BASE + SMALL_SIDE * SMALL_SIDE;
  localparam int LARGE_BASE  = MIDDLE_BASE + MIDDLE_SIDE * MIDDLE_SIDE;
  localparam int TOTAL_SLOTS = LARGE_BASE + LARGE_SIDE * LARGE_SIDE;
  localparam int IDX_W       = $clog2(TOTAL_SLOTS);

  localparam int NUM_W   = 31;
  localparam int PHONE_W = 37;
  localparam int DATA_W  = NUM_W + PHONE_W;
  localparam int ROW_W   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_STORE      = 2'd0,
    OP_FIND_NUM   = 2'd1,
    OP_FIND_PHONE = 2'd2,
    OP_TAKE       = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    POOL_SMALL  = 2'd0,
    POOL_MIDDLE = 2'd1,
    POOL_LARGE  = 2'd2,
    POOL_BAD    = 2'd3
  } pool_e;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TAKEN     = 3'd4,
    ST_BAD_SIZE  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CMD_STORE,
    CMD_BAD_SIZE,
    CMD_FIND_NUM,
    CMD_FIND_PHONE,
    CMD_TAKE
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_e               cmd;
    pool_e              pool;
    logic [NUM_W-1:0]   number;
    logic [PHONE_W-1:0] phone;
  } req_t;

  typedef struct packed {
    pool_e            pool;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } loc_t;

  typedef struct packed {
    status_e            status;
    loc_t               loc;
    logic [NUM_W-1:0]   number;
    logic [PHONE_W-1:0] phone;
    logic               last;
  } res_t;

  function automatic pool_e pool_of(input int i);
    pool_e p;
    if (i >= LARGE_BASE) begin
      p = POOL_LARGE;
    end else if (i >= MIDDLE_BASE) begin
      p = POOL_MIDDLE;
    end else begin
      p = POOL_SMALL;
    end
    return p;
  endfunction

  function automatic loc_t const_loc(input int i);
    loc_t loc;
    if (i >= LARGE_BASE) begin
      loc.pool = POOL_LARGE;
      loc.row  = ROW_W'((i - LARGE_BASE) / LARGE_SIDE);
      loc.col  = ROW_W'((i - LARGE_BASE) % LARGE_SIDE);
    end else if (i >= MIDDLE_BASE) begin
      loc.pool = POOL_MIDDLE;
      loc.row  = ROW_W'((i - MIDDLE_BASE) / MIDDLE_SIDE);
      loc.col  = ROW_W'((i - MIDDLE_BASE) % MIDDLE_SIDE);
    end else begin
      loc.pool = POOL_SMALL;
      loc.row  = ROW_W'((i - SMALL_BASE) / SMALL_SIDE);
      loc.col  = ROW_W'((i - SMALL_BASE) % SMALL_SIDE);
    end
    return loc;
  endfunction

  function automatic loc_t slot_loc(input logic [IDX_W-1:0] idx);
    loc_t loc;
    loc = const_loc(0);
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      if (idx == IDX_W'(i)) begin
        loc = const_loc(i);
      end
    end
    return loc;
  endfunction

endpackage

[src/size_pool_slot_store_lookup_unit.sv]
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in      | input     | in_valid_i / in_stall_o   | opcode, size_class, tracking_number,
//         |           |                           | phone_number
// out     | output    | out_valid_o / out_stall_i | status, pool, row, column,
//         |           |                           | found_number, found_phone, last
//
// store or bad size: the back end takes the transaction from the queue, then registers the result
// find or take out: dequeue, parallel compare, pick and slot read, result;
// when nothing matches, the result follows the compare with no pick or slot read
// find by phone: each further match goes once more through the pick and slot read loop
// reset clears all occupied bits at once, no clearing pass
// a stalled output holds the back end; the front register and a two-entry queue keep
// taking transactions until the queue fills

`include "assert_macros.svh"

module size_pool_slot_store_lookup_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [1:0]                  size_class_i,
  input  logic [sps_pkg::NUM_W-1:0]   tracking_number_i,
  input  logic [sps_pkg::PHONE_W-1:0] phone_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [1:0]                  pool_o,
  output logic [sps_pkg::ROW_W-1:0]   row_o,
  output logic [sps_pkg::ROW_W-1:0]   column_o,
  output logic [sps_pkg::NUM_W-1:0]   found_number_o,
  output logic [sps_pkg::PHONE_W-1:0] found_phone_o,
  output logic                        last_o
);
  import sps_pkg::*;

  logic push_valid;
  logic push_ready;
  req_t push_req;
  logic pop_valid;
  logic back_pop;
  req_t pop_req;
  res_t res;

  sps_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .size_class_i      (size_class_i),
    .tracking_number_i (tracking_number_i),
    .phone_number_i    (phone_number_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .req_o             (push_req)
  );

  sps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_req),
    .pop_valid_o  (pop_valid),
    .pop_i        (back_pop),
    .pop_data_o   (pop_req)
  );

  sps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (back_pop),
    .pop_data_i  (pop_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign status_o       = res.status;
  assign pool_o         = res.loc.pool;
  assign row_o          = res.loc.row;
  assign column_o       = res.loc.col;
  assign found_number_o = res.number;
  assign found_phone_o  = res.phone;
  assign last_o         = res.last;

  `ASSERT_NEVER(a_pop_empty, back_pop && !pop_valid, "back end dequeued from an empty queue")
  `ASSERT_IMPLY(a_no_slot_fields,
    out_valid_o && (status_o == ST_FULL || status_o == ST_NOT_FOUND || status_o == ST_BAD_SIZE),
    last_o && pool_o == POOL_SMALL && row_o == '0 && column_o == '0,
    "result without a slot carries slot fields")
  `ASSERT_IMPLY(a_single_last, out_valid_o && status_o != ST_FOUND, last_o,
    "single-result transaction not marked last")

endmodule

[src/sps_front.sv]
`timescale 1ns / 1ps

module sps_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [1:0]                  size_class_i,
  input  logic [sps_pkg::NUM_W-1:0]   tracking_number_i,
  input  logic [sps_pkg::PHONE_W-1:0] phone_number_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output sps_pkg::req_t               req_o
);
  import sps_pkg::*;

  logic valid_q;
  req_t req_q;
  req_t req_d;
  logic accept;

  assign in_stall_o   = valid_q && !push_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = valid_q;
  assign req_o        = req_q;

  always_comb begin
    req_d.pool   = pool_e'(size_class_i);
    req_d.number = tracking_number_i;
    req_d.phone  = phone_number_i;
    case (opcode_e'(opcode_i))
      OP_STORE:      req_d.cmd = (pool_e'(size_class_i) == POOL_BAD) ? CMD_BAD_SIZE : CMD_STORE;
      OP_FIND_NUM:   req_d.cmd = CMD_FIND_NUM;
      OP_FIND_PHONE: req_d.cmd = CMD_FIND_PHONE;
      OP_TAKE:       req_d.cmd = CMD_TAKE;
      default:       req_d.cmd = CMD_BAD_SIZE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept || (valid_q && !push_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
  end

endmodule

[src/sps_queue.sv]
`timescale 1ns / 1ps

module sps_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  sps_pkg::req_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output sps_pkg::req_t pop_data_o
);
  import sps_pkg::*;

  req_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/sps_back.sv]
`timescale 1ns / 1ps

module sps_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_o,
  input  sps_pkg::req_t pop_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sps_pkg::res_t res_o
);
  import sps_pkg::*;

  back_state_e state_q;
  back_state_e state_d;
  req_t        req_q;

  logic [TOTAL_SLOTS-1:0] used_q;
  logic [TOTAL_SLOTS-1:0] match_q;
  logic [NUM_W-1:0]       num_bank_q   [TOTAL_SLOTS];
  logic [PHONE_W-1:0]     phone_bank_q [TOTAL_SLOTS];
  logic [DATA_W-1:0]      data_mem     [TOTAL_SLOTS];
  logic [DATA_W-1:0]      rd_data_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   rest_q;

  logic                   out_valid_q;
  res_t                   res_q;
  res_t                   res_d;
  logic                   out_load;
  logic                   out_free;

  logic                   bank_we;
  logic                   match_we;
  logic                   pick_we;
  logic                   used_clr;

  logic                   free_hit;
  logic [IDX_W-1:0]       free_idx;
  logic [TOTAL_SLOTS-1:0] match_vec;
  logic                   pick_hit;
  logic [IDX_W-1:0]       pick_idx;
  logic [TOTAL_SLOTS-1:0] pick_onehot;
  logic                   pick_rest;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // first free slot of the requested pool, lowest index wins
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = TOTAL_SLOTS - 1; i >= 0; i--) begin
      if (pool_of(i) == req_q.pool && !used_q[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      if (req_q.cmd == CMD_FIND_PHONE) begin
        match_vec[i] = used_q[i] && (phone_bank_q[i] == req_q.phone);
      end else begin
        match_vec[i] = used_q[i] && (num_bank_q[i] == req_q.number);
      end
    end
  end

  // search order: large pool, then middle, then small, row-major in each
  always_comb begin
    pick_hit    = 1'b0;
    pick_idx    = '0;
    pick_onehot = '0;
    for (int i = MIDDLE_BASE - 1; i >= SMALL_BASE; i--) begin
      if (match_q[i]) begin
        pick_hit    = 1'b1;
        pick_idx    = IDX_W'(i);
        pick_onehot = TOTAL_SLOTS'(1) << i;
      end
    end
    for (int i = LARGE_BASE - 1; i >= MIDDLE_BASE; i--) begin
      if (match_q[i]) begin
        pick_hit    = 1'b1;
        pick_idx    = IDX_W'(i);
        pick_onehot = TOTAL_SLOTS'(1) << i;
      end
    end
    for (int i = TOTAL_SLOTS - 1; i >= LARGE_BASE; i--) begin
      if (match_q[i]) begin
        pick_hit    = 1'b1;
        pick_idx    = IDX_W'(i);
        pick_onehot = TOTAL_SLOTS'(1) << i;
      end
    end
    pick_rest = |(match_q & ~pick_onehot);
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    bank_we  = 1'b0;
    match_we = 1'b0;
    pick_we  = 1'b0;
    used_clr = 1'b0;
    out_load = 1'b0;
    res_d    = '{status: ST_NOT_FOUND, loc: '{pool: POOL_SMALL, row: '0, col: '0},
                 number: '0, phone: '0, last: 1'b1};
    case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        case (req_q.cmd)
          CMD_BAD_SIZE: begin
            res_d.status = ST_BAD_SIZE;
            if (out_free) begin
              out_load = 1'b1;
              state_d  = BK_IDLE;
            end
          end
          CMD_STORE: begin
            if (free_hit) begin
              res_d.status = ST_STORED;
              res_d.loc    = slot_loc(free_idx);
              res_d.number = req_q.number;
              res_d.phone  = req_q.phone;
            end else begin
              res_d.status = ST_FULL;
            end
            if (out_free) begin
              out_load = 1'b1;
              bank_we  = free_hit;
              state_d  = BK_IDLE;
            end
          end
          default: begin
            match_we = 1'b1;
            state_d  = BK_SCAN;
          end
        endcase
      end
      BK_SCAN: begin
        if (pick_hit) begin
          pick_we = 1'b1;
          state_d = BK_EMIT;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      BK_EMIT: begin
        res_d.status = (req_q.cmd == CMD_TAKE) ? ST_TAKEN : ST_FOUND;
        res_d.loc    = slot_loc(idx_q);
        res_d.number = rd_data_q[DATA_W-1:PHONE_W];
        res_d.phone  = rd_data_q[PHONE_W-1:0];
        res_d.last   = (req_q.cmd != CMD_FIND_PHONE) || !rest_q;
        if (out_free) begin
          out_load = 1'b1;
          used_clr = req_q.cmd == CMD_TAKE;
          state_d  = (req_q.cmd == CMD_FIND_PHONE && rest_q) ? BK_SCAN : BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      used_q      <= '0;
      match_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (bank_we) begin
        used_q[free_idx] <= 1'b1;
      end
      if (used_clr) begin
        used_q[idx_q] <= 1'b0;
      end
      if (match_we) begin
        match_q <= match_vec;
      end else if (pick_we) begin
        match_q <= match_q & ~pick_onehot;
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      req_q <= pop_data_i;
    end
    if (bank_we) begin
      num_bank_q[free_idx]   <= req_q.number;
      phone_bank_q[free_idx] <= req_q.phone;
    end
    if (pick_we) begin
      idx_q  <= pick_idx;
      rest_q <= pick_rest;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  // slot contents for the result read
  always_ff @(posedge clk_i) begin
    if (bank_we) begin
      data_mem[free_idx] <= {req_q.number, req_q.phone};
    end
    if (pick_we) begin
      rd_data_q <= data_mem[pick_idx];
    end
  end

endmodule
